### src/assert_macros.svh
// Assertion macros shared by the layer decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define RLD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define RLD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/rld_pkg.sv
// Shared types, constants and the FNV-1a step for the layer decoder.
package rld_pkg;

	localparam logic [31:0] LAYER_MAGIC   = 32'h3143_564e;
	localparam logic [31:0] LAYER_VERSION = 32'h0000_0001;
	localparam logic [31:0] FNV_BASIS     = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME     = 32'd16777619;
	localparam int          HDR_BYTES     = 16;
	localparam logic [30:0] CAP_RESET     = 31'h7fff_ffff;

	// Status codes carried by the final word of a layer.
	localparam logic [3:0] ERR_NONE       = 4'd0;
	localparam logic [3:0] ERR_SHORT_HDR  = 4'd1;
	localparam logic [3:0] ERR_BAD_HDR    = 4'd2;
	localparam logic [3:0] ERR_CAPACITY   = 4'd3;
	localparam logic [3:0] ERR_OVERRUN    = 4'd4;
	localparam logic [3:0] ERR_TRUNC      = 4'd5;
	localparam logic [3:0] ERR_TRAILING   = 4'd6;
	localparam logic [3:0] ERR_SIZE_SHORT = 4'd7;
	localparam logic [3:0] ERR_CHECKSUM   = 4'd8;

	typedef enum logic [1:0] {
		PH_TAG,
		PH_RUN,
		PH_LIT
	} phase_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_HASH,
		CS_STATUS
	} ctrl_state_t;

	typedef struct packed {
		logic step;         // process the byte accepted this cycle
		logic absorb;       // hash one more copy of the held run byte
		logic push_status;  // load the status word and clear the layer
	} cmd_t;

	typedef struct packed {
		logic out_free;     // output register can take a word this cycle
		logic run_more;     // the byte at the input is a run value needing extra hash cycles
		logic loop_last;    // the current hash cycle is the last one of the run
	} sts_t;

	// One FNV-1a round; the multiply is by a constant and maps to shift-adds.
	function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] x;
		x = h ^ {24'd0, b};
		return x * FNV_PRIME;
	endfunction

endpackage

### src/rle_layer_decompressor.sv
// Top level of the run-length layer decoder with FNV-1a 32 integrity check.
// Header, tag and literal bytes are taken one per cycle while the output register is
// free; a literal word appears on the output register the cycle after its byte is
// accepted. A run value byte blocks further input while the hash loop hashes its
// remaining copies, since the FNV-1a round unit hashes one expanded byte per cycle.
// After the last byte of a layer the status word is loaded into the output register.
// Reset (arst_n low) clears all layer state and sets the capacity to its maximum.
module rle_layer_decompressor (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: the output capacity register, written when cfg_wr_en is high.
	input  logic        cfg_wr_en,
	input  logic [30:0] cfg_wr_data,
	// Compressed input words.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        last_byte,
	// Decompressed output words and the final status word of each layer.
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic [7:0]  repeat_count,
	output logic        is_status,
	output logic [3:0]  status,
	output logic [30:0] total_bytes
);
	import rld_pkg::*;

	// The controller decides when a word is taken, when the run hash loop runs and
	// when the status word is loaded. The datapath holds every layer register and
	// the single output register, which decouples the two sides: a new word is
	// accepted in the same cycle the previous output word leaves.
	cmd_t cmd;
	sts_t sts;

	rld_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_byte (last_byte),
		.in_ready  (in_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Data words are tentative: only a status word of zero confirms the layer.
	rld_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_byte      (in_byte),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.out_byte     (out_byte),
		.repeat_count (repeat_count),
		.is_status    (is_status),
		.status       (status),
		.total_bytes  (total_bytes)
	);

endmodule

### src/rld_ctrl.sv
// Controller state machine: input handshake, run hash loop and status sequencing.
`include "assert_macros.svh"

module rld_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          last_byte,
	output logic          in_ready,
	input  rld_pkg::sts_t sts,
	output rld_pkg::cmd_t cmd
);
	import rld_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        last_q;
	logic        accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				last_q <= last_byte;
			end
		end
	end

	always_comb begin
		state_d         = state_q;
		in_ready        = 1'b0;
		accept          = 1'b0;
		cmd.step        = 1'b0;
		cmd.absorb      = 1'b0;
		cmd.push_status = 1'b0;
		case (state_q)
			CS_IDLE: begin
				// A byte may push a data word, so the output register must be free.
				in_ready = sts.out_free;
				accept   = in_valid && in_ready;
				cmd.step = accept;
				if (accept) begin
					if (sts.run_more) begin
						state_d = CS_HASH;
					end else if (last_byte) begin
						state_d = CS_STATUS;
					end
				end
			end
			CS_HASH: begin
				cmd.absorb = 1'b1;
				if (sts.loop_last) begin
					state_d = last_q ? CS_STATUS : CS_IDLE;
				end
			end
			CS_STATUS: begin
				if (sts.out_free) begin
					cmd.push_status = 1'b1;
					state_d         = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	`RLD_ASSERT_NXT(a_last_goes_status, in_valid && in_ready && last_byte && !sts.run_more, state_q == CS_STATUS, "last byte without run did not lead to status")
	`RLD_ASSERT_NXT(a_run_end_idle, state_q == CS_HASH && sts.loop_last && !last_q, state_q == CS_IDLE, "run hash loop did not return to idle")

endmodule

### src/rld_dp.sv
// Datapath: header parsing, token tracking, FNV-1a hash, counters and output register.
`include "assert_macros.svh"

module rld_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  rld_pkg::cmd_t cmd,
	output rld_pkg::sts_t sts,
	input  logic [7:0]    in_byte,
	input  logic          cfg_wr_en,
	input  logic [30:0]   cfg_wr_data,
	input  logic          out_ready,
	output logic          out_valid,
	output logic [7:0]    out_byte,
	output logic [7:0]    repeat_count,
	output logic          is_status,
	output logic [3:0]    status,
	output logic [30:0]   total_bytes
);
	import rld_pkg::*;

	logic [30:0] cap_q;
	logic [4:0]  hdr_idx_q, hdr_idx_d;
	logic        good_q, good_d;
	logic [31:0] raw_q, raw_d;
	logic [31:0] exp_q, exp_d;
	logic [31:0] hash_q, hash_d;
	logic [30:0] prod_q, prod_d;
	phase_t      phase_q, phase_d;
	logic [7:0]  rem_q, rem_d;
	logic [3:0]  err_q, err_d;
	logic [6:0]  loop_q, loop_d;
	logic [7:0]  run_byte_q;

	logic        out_valid_q, out_valid_d;
	logic [7:0]  out_byte_q, out_byte_d;
	logic [7:0]  rep_q, rep_d;
	logic        is_stat_q, is_stat_d;
	logic [3:0]  stat_q, stat_d;
	logic [30:0] total_q, total_d;
	logic        push;

	logic [1:0]  lane;
	logic [4:0]  lane_bit;
	logic [7:0]  cnt;
	logic [32:0] need;
	logic [3:0]  fin_code;

	assign lane     = hdr_idx_q[1:0];
	assign lane_bit = {lane, 3'b000};
	assign cnt      = {1'b0, in_byte[6:0]} + 8'd1;
	assign need     = {2'b00, prod_q} + {25'd0, cnt};

	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.run_more  = (err_q == ERR_NONE) && hdr_idx_q[4] && (phase_q == PH_RUN)
		&& (rem_q > 8'd1);
	assign sts.loop_last = (loop_q == 7'd1);

	// End-of-layer code: the first error wins, then the checks in priority order.
	always_comb begin
		if (err_q != ERR_NONE) begin
			fin_code = err_q;
		end else if (!hdr_idx_q[4]) begin
			fin_code = ERR_SHORT_HDR;
		end else if (phase_q != PH_TAG) begin
			fin_code = ERR_TRUNC;
		end else if ({1'b0, prod_q} != raw_q) begin
			fin_code = ERR_SIZE_SHORT;
		end else if (hash_q != exp_q) begin
			fin_code = ERR_CHECKSUM;
		end else begin
			fin_code = ERR_NONE;
		end
	end

	always_comb begin
		hdr_idx_d  = hdr_idx_q;
		good_d     = good_q;
		raw_d      = raw_q;
		exp_d      = exp_q;
		hash_d     = hash_q;
		prod_d     = prod_q;
		phase_d    = phase_q;
		rem_d      = rem_q;
		err_d      = err_q;
		loop_d     = loop_q;
		push       = 1'b0;
		out_byte_d = out_byte_q;
		rep_d      = rep_q;
		is_stat_d  = is_stat_q;
		stat_d     = stat_q;
		total_d    = total_q;

		if (cmd.step && err_q == ERR_NONE) begin
			if (!hdr_idx_q[4]) begin
				case (hdr_idx_q[3:2])
					2'd0: begin
						if (in_byte != LAYER_MAGIC[lane_bit +: 8]) begin
							good_d = 1'b0;
						end
					end
					2'd1: begin
						if (in_byte != LAYER_VERSION[lane_bit +: 8]) begin
							good_d = 1'b0;
						end
					end
					2'd2: begin
						raw_d[lane_bit +: 8] = in_byte;
					end
					default: begin
						exp_d[lane_bit +: 8] = in_byte;
					end
				endcase
				hdr_idx_d = hdr_idx_q + 5'd1;
				if (hdr_idx_q == 5'(HDR_BYTES - 1)) begin
					if (!good_d) begin
						err_d = ERR_BAD_HDR;
					end else if (raw_d > {1'b0, cap_q}) begin
						err_d = ERR_CAPACITY;
					end
				end
			end else begin
				case (phase_q)
					PH_TAG: begin
						if ({1'b0, prod_q} >= raw_q) begin
							err_d = ERR_TRAILING;
						end else if (need > {1'b0, raw_q}) begin
							err_d = ERR_OVERRUN;
						end else begin
							rem_d   = cnt;
							phase_d = in_byte[7] ? PH_RUN : PH_LIT;
						end
					end
					PH_RUN: begin
						// First copy is hashed now, the rest in the hash loop.
						hash_d     = fnv_step(hash_q, in_byte);
						prod_d     = prod_q + {23'd0, rem_q};
						loop_d     = 7'(rem_q - 8'd1);
						push       = 1'b1;
						out_byte_d = in_byte;
						rep_d      = rem_q;
						is_stat_d  = 1'b0;
						stat_d     = ERR_NONE;
						total_d    = '0;
						rem_d      = '0;
						phase_d    = PH_TAG;
					end
					PH_LIT: begin
						hash_d     = fnv_step(hash_q, in_byte);
						prod_d     = prod_q + 31'd1;
						push       = 1'b1;
						out_byte_d = in_byte;
						rep_d      = 8'd1;
						is_stat_d  = 1'b0;
						stat_d     = ERR_NONE;
						total_d    = '0;
						rem_d      = rem_q - 8'd1;
						if (rem_q == 8'd1) begin
							phase_d = PH_TAG;
						end
					end
					default: begin
						phase_d = PH_TAG;
					end
				endcase
			end
		end

		if (cmd.absorb) begin
			hash_d = fnv_step(hash_q, run_byte_q);
			loop_d = loop_q - 7'd1;
		end

		if (cmd.push_status) begin
			push       = 1'b1;
			out_byte_d = '0;
			rep_d      = '0;
			is_stat_d  = 1'b1;
			stat_d     = fin_code;
			total_d    = (fin_code == ERR_NONE) ? prod_q : '0;
			hdr_idx_d  = '0;
			good_d     = 1'b1;
			raw_d      = '0;
			exp_d      = '0;
			hash_d     = FNV_BASIS;
			prod_d     = '0;
			phase_d    = PH_TAG;
			rem_d      = '0;
			err_d      = ERR_NONE;
		end

		if (push) begin
			out_valid_d = 1'b1;
		end else begin
			out_valid_d = out_valid_q && !out_ready;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			hdr_idx_q   <= '0;
			good_q      <= 1'b1;
			raw_q       <= '0;
			exp_q       <= '0;
			hash_q      <= FNV_BASIS;
			prod_q      <= '0;
			phase_q     <= PH_TAG;
			rem_q       <= '0;
			err_q       <= ERR_NONE;
			loop_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			hdr_idx_q   <= hdr_idx_d;
			good_q      <= good_d;
			raw_q       <= raw_d;
			exp_q       <= exp_d;
			hash_q      <= hash_d;
			prod_q      <= prod_d;
			phase_q     <= phase_d;
			rem_q       <= rem_d;
			err_q       <= err_d;
			loop_q      <= loop_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			run_byte_q <= in_byte;
		end
		if (push) begin
			out_byte_q <= out_byte_d;
			rep_q      <= rep_d;
			is_stat_q  <= is_stat_d;
			stat_q     <= stat_d;
			total_q    <= total_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign repeat_count = rep_q;
	assign is_status    = is_stat_q;
	assign status       = stat_q;
	assign total_bytes  = total_q;

	`RLD_ASSERT_IMP(a_loop_nonzero, cmd.absorb, loop_q != 7'd0, "hash loop ran with an empty count")
	`RLD_ASSERT_NXT(a_status_loaded, cmd.push_status, out_valid_q && is_stat_q, "status word was not loaded")
	`RLD_ASSERT_NXT(a_layer_cleared, cmd.push_status, hdr_idx_q == 5'd0 && err_q == ERR_NONE && hash_q == FNV_BASIS, "layer state not cleared after status")

endmodule
